// ===== sv/prtc_pkg.sv =====
`timescale 1ns / 1ps
package prtc_pkg;

    // operation codes carried on s_tuser
    localparam logic [2:0] OP_NEW   = 3'd0;
    localparam logic [2:0] OP_DEL   = 3'd1;
    localparam logic [2:0] OP_MOD   = 3'd2;
    localparam logic [2:0] OP_TRADE = 3'd3;
    localparam logic [2:0] OP_DISC  = 3'd4;

    // response status codes carried on m_tuser
    localparam logic [1:0] ST_ACCEPT = 2'd0;
    localparam logic [1:0] ST_LIMIT  = 2'd1;
    localparam logic [1:0] ST_FULL   = 2'd2;

    localparam int KEY_W    = 64;
    localparam int QTY_W    = 32;
    localparam int TRADER_W = 8;
    localparam int LIMIT_W  = 31;

    // control for the position arithmetic
    typedef struct packed {
        logic [2:0] op;
        logic       side_sel;
    } calc_ctl_t;

endpackage

// ===== sv/prtc_ram.sv =====
`timescale 1ns / 1ps
module prtc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== sv/prtc_calc.sv =====
`timescale 1ns / 1ps
module prtc_calc #(
    parameter int PB = 48
) (
    input  logic                                aclk,
    input  prtc_pkg::calc_ctl_t                 ctl,
    input  logic signed [PB-1:0]                net_i,
    input  logic [PB-1:0]                       ob_i,
    input  logic [PB-1:0]                       os_i,
    input  logic [prtc_pkg::QTY_W-1:0]          qty_i,
    input  logic [prtc_pkg::QTY_W-1:0]          oqty_i,
    input  logic signed [prtc_pkg::QTY_W-1:0]   tq_i,
    input  logic [prtc_pkg::LIMIT_W-1:0]        limit_i,
    output logic signed [PB-1:0]                net_o,
    output logic [PB-1:0]                       ob_o,
    output logic [PB-1:0]                       os_o,
    output logic                                reject_o
);
    import prtc_pkg::*;

    localparam logic [PB-1:0]        UMAX = '1;
    localparam logic signed [PB:0]   NMAX = {2'b00, {(PB-1){1'b1}}};
    localparam logic signed [PB:0]   NMIN = {2'b11, {(PB-1){1'b0}}};

    logic [PB-1:0]        open_sel, qty_x, oqty_x, long_c, short_c;
    logic [PB:0]          sum1, sum2, sum3, neg_c;
    logic signed [PB:0]   net_sum;
    logic [PB-1:0]        t1_next, t1_reg, mag_next, mag_reg;
    logic signed [PB-1:0] net1_next, net1_reg;
    logic [PB-1:0]        cand, modv, upd;
    logic signed [PB-1:0] net_next;
    logic [PB-1:0]        ob_next, os_next;
    logic                 reject_next;

    // first stage: open figure update and net saturation
    always_comb begin
        open_sel = ctl.side_sel ? ob_i : os_i;
        qty_x    = {{(PB-QTY_W){1'b0}}, qty_i};
        oqty_x   = {{(PB-QTY_W){1'b0}}, oqty_i};
        sum1     = {1'b0, open_sel} + {1'b0, qty_x};
        if (ctl.op == OP_NEW) begin
            t1_next = sum1[PB] ? UMAX : sum1[PB-1:0];
        end else begin
            t1_next = (open_sel > oqty_x) ? (open_sel - oqty_x) : '0;
        end
        neg_c    = -{net_i[PB-1], net_i};
        long_c   = (net_i > 0) ? net_i : '0;
        short_c  = (net_i < 0) ? neg_c[PB-1:0] : '0;
        mag_next = ctl.side_sel ? long_c : short_c;
        net_sum  = {net_i[PB-1], net_i} + {{(PB+1-QTY_W){tq_i[QTY_W-1]}}, tq_i};
        if (net_sum > NMAX) begin
            net1_next = NMAX[PB-1:0];
        end else if (net_sum < NMIN) begin
            net1_next = NMIN[PB-1:0];
        end else begin
            net1_next = net_sum[PB-1:0];
        end
    end

    // second stage: worst-case check and final figures
    always_comb begin
        sum2        = {1'b0, t1_reg} + {1'b0, mag_reg};
        cand        = sum2[PB] ? UMAX : sum2[PB-1:0];
        sum3        = {1'b0, t1_reg} + {1'b0, qty_x};
        modv        = sum3[PB] ? UMAX : sum3[PB-1:0];
        upd         = (ctl.op == OP_MOD) ? modv : t1_reg;
        reject_next = cand > {{(PB-LIMIT_W){1'b0}}, limit_i};
        ob_next     = ob_i;
        os_next     = os_i;
        net_next    = net_i;
        if (ctl.op == OP_TRADE) begin
            net_next = net1_reg;
        end else if (ctl.side_sel) begin
            ob_next = upd;
        end else begin
            os_next = upd;
        end
    end

    always_ff @(posedge aclk) begin
        t1_reg   <= t1_next;
        mag_reg  <= mag_next;
        net1_reg <= net1_next;
        net_o    <= net_next;
        ob_o     <= ob_next;
        os_o     <= os_next;
        reject_o <= reject_next;
    end

endmodule

// ===== sv/pretrade_position_risk_check.sv =====
`timescale 1ns / 1ps
// Pre-trade risk check with worst-case position limits.
// Input beats arrive on s_* (op on s_tuser); only a new order produces a
// response beat on m_* giving the order id, trader and accept/reject status.
// Delete, modify, trade and disconnect update the tables silently.
// Orders and positions live in two RAMs with one write and one read port and
// registered reads; every lookup is a linear sweep, one entry per cycle.
// Each item runs an order-table sweep to the first hit (not for a trade), a
// position-table sweep to the first hit (only for a new order, a trade or a
// found order), the arithmetic states S_C1 and S_C2 and a write state; one
// item at a time, s_tready high only while idle. A disconnect repeats the
// position sweep and write for every order the trader owns while walking
// the order table. Reset clears both valid-bit arrays and the limits; RAM
// contents are left. When the receiver stalls, the response is held in its
// output register and the next item is still taken; a further new order
// waits in its write cycle. Limits are written over APB at 0x0 (buy) and 0x4
// (sell); the user must do so only while idle; the block does not enforce it.
module pretrade_position_risk_check #(
    parameter int INSTRUMENT_SLOTS = 64,
    parameter int ORDER_SLOTS      = 256,
    parameter int POSITION_BITS    = 48
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // trader_id, order_id, instrument_id, side, quantity, trade_quantity, pad
    input  logic [207:0] s_tdata,
    // op
    input  logic [2:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // resp_order_id, resp_trader_id
    output logic [71:0]  m_tdata,
    // status
    output logic [1:0]   m_tuser,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);
    import prtc_pkg::*;

    localparam int PB    = POSITION_BITS;
    localparam int PIW   = $clog2(INSTRUMENT_SLOTS);
    localparam int OIW   = $clog2(ORDER_SLOTS);
    localparam logic [PIW-1:0] P_LAST = PIW'(INSTRUMENT_SLOTS - 1);
    localparam logic [OIW-1:0] O_LAST = OIW'(ORDER_SLOTS - 1);

    // order entry layout: key, quantity, instrument, side, owner
    localparam int ORD_W = KEY_W + QTY_W + KEY_W + 1 + TRADER_W;
    localparam int OQ_LO = KEY_W;
    localparam int OI_LO = KEY_W + QTY_W;
    localparam int OS_B  = OI_LO + KEY_W;
    localparam int OW_LO = OS_B + 1;
    // position entry layout: instrument, net, open buy, open sell
    localparam int POS_W = KEY_W + 3 * PB;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_OSCAN = 6'b000010,
        S_PSCAN = 6'b000100,
        S_C1    = 6'b001000,
        S_C2    = 6'b010000,
        S_WRITE = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    logic [2:0]          op_reg, op_next;
    logic [TRADER_W-1:0] trader_reg, trader_next;
    logic [KEY_W-1:0]    key_reg, key_next, inst_reg, inst_next;
    logic                side_reg, side_next;
    logic [QTY_W-1:0]    qty_reg, qty_next;
    logic signed [QTY_W-1:0] tq_reg, tq_next;

    logic [OIW-1:0] o_addr_reg, o_addr_next, o_ridx_reg, o_ridx_next;
    logic           o_liss_reg, o_liss_next, o_pend_reg, o_pend_next;
    logic [PIW-1:0] p_addr_reg, p_addr_next, p_ridx_reg, p_ridx_next;
    logic           p_liss_reg, p_liss_next, p_pend_reg, p_pend_next;

    logic           k_hit_reg, k_hit_next, k_ff_reg, k_ff_next;
    logic [OIW-1:0] k_idx_reg, k_idx_next, k_fidx_reg, k_fidx_next;
    logic           p_hit_reg, p_hit_next, p_ff_reg, p_ff_next;
    logic [PIW-1:0] p_idx_reg, p_idx_next, p_fidx_reg, p_fidx_next;

    logic [ORD_W-1:0]     o_ent_reg, o_ent_next;
    logic signed [PB-1:0] ent_net_reg, ent_net_next;
    logic [PB-1:0]        ent_ob_reg, ent_ob_next, ent_os_reg, ent_os_next;

    logic [INSTRUMENT_SLOTS-1:0] pos_valid_reg;
    logic [ORDER_SLOTS-1:0]      ord_valid_reg;

    logic                m_tvalid_reg, m_tvalid_next;
    logic [KEY_W-1:0]    m_order_reg, m_order_next;
    logic [TRADER_W-1:0] m_trader_reg, m_trader_next;
    logic [1:0]          m_status_reg, m_status_next;
    logic [LIMIT_W-1:0]  buy_limit_reg, sell_limit_reg;

    logic [ORD_W-1:0] ord_rdata, ord_wdata;
    logic [POS_W-1:0] pos_rdata, pos_wdata;
    logic [OIW-1:0]   ord_waddr;
    logic [PIW-1:0]   pos_waddr;
    logic             ord_we, pos_we, ord_set, ord_clr, m_load, s_acc, empty;
    logic             o_hit_c, p_hit_c;
    logic [KEY_W-1:0] p_key;

    calc_ctl_t            ctl;
    logic signed [PB-1:0] c_net;
    logic [PB-1:0]        c_ob, c_os;
    logic                 c_reject;

    prtc_ram #(.WIDTH(ORD_W), .DEPTH(ORDER_SLOTS)) u_ord_ram (
        .clk   (aclk),
        .we    (ord_we),
        .waddr (ord_waddr),
        .wdata (ord_wdata),
        .raddr (o_addr_reg),
        .rdata (ord_rdata)
    );

    prtc_ram #(.WIDTH(POS_W), .DEPTH(INSTRUMENT_SLOTS)) u_pos_ram (
        .clk   (aclk),
        .we    (pos_we),
        .waddr (pos_waddr),
        .wdata (pos_wdata),
        .raddr (p_addr_reg),
        .rdata (pos_rdata)
    );

    assign ctl.op       = op_reg;
    assign ctl.side_sel = (op_reg == OP_NEW) ? side_reg : o_ent_reg[OS_B];

    prtc_calc #(.PB(PB)) u_calc (
        .aclk     (aclk),
        .ctl      (ctl),
        .net_i    (ent_net_reg),
        .ob_i     (ent_ob_reg),
        .os_i     (ent_os_reg),
        .qty_i    (qty_reg),
        .oqty_i   (o_ent_reg[OI_LO-1:OQ_LO]),
        .tq_i     (tq_reg),
        .limit_i  (side_reg ? buy_limit_reg : sell_limit_reg),
        .net_o    (c_net),
        .ob_o     (c_ob),
        .os_o     (c_os),
        .reject_o (c_reject)
    );

    assign s_tready = (state_reg == S_IDLE);
    assign s_acc    = s_tvalid && s_tready;

    // match on the entry read back last cycle
    assign o_hit_c = ord_valid_reg[o_ridx_reg] &&
                     ((op_reg == OP_DISC) ? (ord_rdata[ORD_W-1:OW_LO] == trader_reg)
                                          : (ord_rdata[KEY_W-1:0] == key_reg));
    assign p_key   = (op_reg == OP_NEW || op_reg == OP_TRADE) ? inst_reg
                                                              : o_ent_reg[OS_B-1:OI_LO];
    assign p_hit_c = pos_valid_reg[p_ridx_reg] && (pos_rdata[KEY_W-1:0] == p_key);
    assign empty   = (c_net == '0) && (c_ob == '0) && (c_os == '0);

    assign pos_waddr = p_hit_reg ? p_idx_reg : p_fidx_reg;
    assign pos_wdata = {c_os, c_ob, c_net, p_key};

    always_comb begin
        state_next    = state_reg;
        op_next       = op_reg;
        trader_next   = trader_reg;
        key_next      = key_reg;
        inst_next     = inst_reg;
        side_next     = side_reg;
        qty_next      = qty_reg;
        tq_next       = tq_reg;
        o_addr_next   = o_addr_reg;
        o_ridx_next   = o_ridx_reg;
        o_liss_next   = o_liss_reg;
        o_pend_next   = 1'b0;
        p_addr_next   = p_addr_reg;
        p_ridx_next   = p_ridx_reg;
        p_liss_next   = p_liss_reg;
        p_pend_next   = 1'b0;
        k_hit_next    = k_hit_reg;
        k_ff_next     = k_ff_reg;
        k_idx_next    = k_idx_reg;
        k_fidx_next   = k_fidx_reg;
        p_hit_next    = p_hit_reg;
        p_ff_next     = p_ff_reg;
        p_idx_next    = p_idx_reg;
        p_fidx_next   = p_fidx_reg;
        o_ent_next    = o_ent_reg;
        ent_net_next  = ent_net_reg;
        ent_ob_next   = ent_ob_reg;
        ent_os_next   = ent_os_reg;
        m_order_next  = m_order_reg;
        m_trader_next = m_trader_reg;
        m_status_next = m_status_reg;
        m_load        = 1'b0;
        ord_we        = 1'b0;
        pos_we        = 1'b0;
        ord_set       = 1'b0;
        ord_clr       = 1'b0;
        ord_waddr     = k_idx_reg;
        ord_wdata     = {o_ent_reg[ORD_W-1:OI_LO], qty_reg, o_ent_reg[KEY_W-1:0]};

        unique case (state_reg)
            S_IDLE: begin
                if (s_acc) begin
                    op_next     = s_tuser;
                    trader_next = s_tdata[7:0];
                    key_next    = s_tdata[71:8];
                    inst_next   = s_tdata[135:72];
                    side_next   = s_tdata[136];
                    qty_next    = s_tdata[168:137];
                    tq_next     = s_tdata[200:169];
                    o_addr_next = '0;
                    o_liss_next = 1'b0;
                    k_hit_next  = 1'b0;
                    k_ff_next   = 1'b0;
                    p_addr_next = '0;
                    p_liss_next = 1'b0;
                    p_hit_next  = 1'b0;
                    p_ff_next   = 1'b0;
                    case (s_tuser) inside
                        OP_NEW, OP_DEL, OP_MOD, OP_DISC: state_next = S_OSCAN;
                        OP_TRADE:                        state_next = S_PSCAN;
                        default:                         state_next = S_IDLE;
                    endcase
                end
            end
            S_OSCAN: begin
                // issue the next address until the last one is out
                if (!o_liss_reg) begin
                    o_pend_next = 1'b1;
                    o_ridx_next = o_addr_reg;
                    o_addr_next = o_addr_reg + 1'b1;
                    o_liss_next = (o_addr_reg == O_LAST);
                end
                if (o_pend_reg) begin
                    if (!ord_valid_reg[o_ridx_reg] && !k_ff_reg) begin
                        k_ff_next   = 1'b1;
                        k_fidx_next = o_ridx_reg;
                    end
                    if (o_hit_c) begin
                        k_hit_next  = 1'b1;
                        k_idx_next  = o_ridx_reg;
                        o_ent_next  = ord_rdata;
                        state_next  = S_PSCAN;
                        p_addr_next = '0;
                        p_liss_next = 1'b0;
                        p_hit_next  = 1'b0;
                        p_ff_next   = 1'b0;
                    end else if (o_ridx_reg == O_LAST) begin
                        if (op_reg == OP_NEW) begin
                            state_next  = S_PSCAN;
                            p_addr_next = '0;
                            p_liss_next = 1'b0;
                            p_hit_next  = 1'b0;
                            p_ff_next   = 1'b0;
                        end else begin
                            state_next = S_IDLE;
                        end
                    end
                end
            end
            S_PSCAN: begin
                if (!p_liss_reg) begin
                    p_pend_next = 1'b1;
                    p_ridx_next = p_addr_reg;
                    p_addr_next = p_addr_reg + 1'b1;
                    p_liss_next = (p_addr_reg == P_LAST);
                end
                if (p_pend_reg) begin
                    if (!pos_valid_reg[p_ridx_reg] && !p_ff_reg) begin
                        p_ff_next   = 1'b1;
                        p_fidx_next = p_ridx_reg;
                    end
                    if (p_hit_c) begin
                        p_hit_next   = 1'b1;
                        p_idx_next   = p_ridx_reg;
                        ent_net_next = pos_rdata[KEY_W+PB-1:KEY_W];
                        ent_ob_next  = pos_rdata[KEY_W+2*PB-1:KEY_W+PB];
                        ent_os_next  = pos_rdata[POS_W-1:KEY_W+2*PB];
                        state_next   = S_C1;
                    end else if (p_ridx_reg == P_LAST) begin
                        // unknown instrument: work from a zero entry
                        ent_net_next = '0;
                        ent_ob_next  = '0;
                        ent_os_next  = '0;
                        state_next   = S_C1;
                    end
                end
            end
            S_C1: begin
                state_next = S_C2;
            end
            S_C2: begin
                state_next = S_WRITE;
            end
            S_WRITE: begin
                state_next = S_IDLE;
                case (op_reg)
                    OP_NEW: begin
                        if (m_tvalid_reg && !m_tready) begin
                            // hold until the previous response is taken
                            state_next = S_WRITE;
                        end else begin
                            m_load        = 1'b1;
                            m_order_next  = key_reg;
                            m_trader_next = trader_reg;
                            if (c_reject) begin
                                m_status_next = ST_LIMIT;
                            end else if (k_hit_reg || !k_ff_reg || (!p_hit_reg && !p_ff_reg)) begin
                                m_status_next = ST_FULL;
                            end else begin
                                m_status_next = ST_ACCEPT;
                                pos_we        = 1'b1;
                                ord_we        = 1'b1;
                                ord_set       = 1'b1;
                                ord_waddr     = k_fidx_reg;
                                ord_wdata     = {trader_reg, side_reg, inst_reg, qty_reg, key_reg};
                            end
                        end
                    end
                    OP_DEL, OP_DISC: begin
                        pos_we  = p_hit_reg;
                        ord_clr = 1'b1;
                        if (op_reg == OP_DISC && k_idx_reg != O_LAST) begin
                            // resume the walk past the order just dropped
                            state_next  = S_OSCAN;
                            o_addr_next = k_idx_reg + 1'b1;
                            o_liss_next = 1'b0;
                            k_hit_next  = 1'b0;
                        end
                    end
                    OP_MOD: begin
                        if (p_hit_reg || p_ff_reg) begin
                            pos_we = 1'b1;
                            ord_we = 1'b1;
                        end
                    end
                    OP_TRADE: begin
                        pos_we = p_hit_reg || (p_ff_reg && (tq_reg != '0));
                    end
                    default: begin
                        state_next = S_IDLE;
                    end
                endcase
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase

        if (m_load) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end else begin
            m_tvalid_next = m_tvalid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            o_pend_reg     <= 1'b0;
            p_pend_reg     <= 1'b0;
            o_liss_reg     <= 1'b0;
            p_liss_reg     <= 1'b0;
            k_hit_reg      <= 1'b0;
            k_ff_reg       <= 1'b0;
            p_hit_reg      <= 1'b0;
            p_ff_reg       <= 1'b0;
            m_tvalid_reg   <= 1'b0;
            pos_valid_reg  <= '0;
            ord_valid_reg  <= '0;
            buy_limit_reg  <= '0;
            sell_limit_reg <= '0;
        end else begin
            state_reg    <= state_next;
            o_pend_reg   <= o_pend_next;
            p_pend_reg   <= p_pend_next;
            o_liss_reg   <= o_liss_next;
            p_liss_reg   <= p_liss_next;
            k_hit_reg    <= k_hit_next;
            k_ff_reg     <= k_ff_next;
            p_hit_reg    <= p_hit_next;
            p_ff_reg     <= p_ff_next;
            m_tvalid_reg <= m_tvalid_next;
            if (pos_we) begin
                // drop a position that has gone all zero
                pos_valid_reg[pos_waddr] <= !empty;
            end
            if (ord_set) begin
                ord_valid_reg[k_fidx_reg] <= 1'b1;
            end
            if (ord_clr) begin
                ord_valid_reg[k_idx_reg] <= 1'b0;
            end
            if (psel && penable && pwrite && pready) begin
                if (paddr[2]) begin
                    sell_limit_reg <= pwdata[LIMIT_W-1:0];
                end else begin
                    buy_limit_reg <= pwdata[LIMIT_W-1:0];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        op_reg       <= op_next;
        trader_reg   <= trader_next;
        key_reg      <= key_next;
        inst_reg     <= inst_next;
        side_reg     <= side_next;
        qty_reg      <= qty_next;
        tq_reg       <= tq_next;
        o_addr_reg   <= o_addr_next;
        o_ridx_reg   <= o_ridx_next;
        p_addr_reg   <= p_addr_next;
        p_ridx_reg   <= p_ridx_next;
        k_idx_reg    <= k_idx_next;
        k_fidx_reg   <= k_fidx_next;
        p_idx_reg    <= p_idx_next;
        p_fidx_reg   <= p_fidx_next;
        o_ent_reg    <= o_ent_next;
        ent_net_reg  <= ent_net_next;
        ent_ob_reg   <= ent_ob_next;
        ent_os_reg   <= ent_os_next;
        m_order_reg  <= m_order_next;
        m_trader_reg <= m_trader_next;
        m_status_reg <= m_status_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {m_trader_reg, m_order_reg};
    assign m_tuser  = m_status_reg;
    assign pready   = 1'b1;
    assign prdata   = paddr[2] ? {1'b0, sell_limit_reg} : {1'b0, buy_limit_reg};

`ifndef ASSERT_OFF
    // a response beat is only ever produced by a new order
    a_resp_new_only: assert property (@(posedge aclk) disable iff (!aresetn)
        m_load |-> (op_reg == OP_NEW))
        else $error("response loaded for an op other than new order");

    // a pending response is never overwritten
    a_resp_no_clobber: assert property (@(posedge aclk) disable iff (!aresetn)
        m_load |-> (!m_tvalid_reg || m_tready))
        else $error("response register overwritten while stalled");

    // an accepted order occupies its slot afterwards
    a_ord_slot_taken: assert property (@(posedge aclk) disable iff (!aresetn)
        ord_set |=> ord_valid_reg[$past(k_fidx_reg)])
        else $error("accepted order slot not marked valid");
`endif

endmodule

// ===== tb/sv/pretrade_position_risk_check_tb.sv =====
`timescale 1ns / 1ps
module pretrade_position_risk_check_tb;
    import prtc_pkg::*;

    localparam int POS_SLOTS   = 64;
    localparam int ORD_SLOTS   = 256;
    localparam int IDLE_LIMIT  = 100000;
    localparam int HOLD_CYCLES = 400;
    localparam int KEY_POOL    = 400;
    localparam int INST_POOL   = 80;
    localparam logic [2:0] ADDR_BUY  = 3'd0;
    localparam logic [2:0] ADDR_SELL = 3'd4;
    localparam longint unsigned POS_UMAX = 64'h0000_FFFF_FFFF_FFFF;
    localparam longint          POS_NMAX = 64'h0000_7FFF_FFFF_FFFF;
    localparam logic [30:0] LIM_MAX = 31'h7FFF_FFFF;

    typedef struct {
        logic [2:0]         op;
        logic [7:0]         trader;
        logic [63:0]        oid;
        logic [63:0]        inst;
        logic               side;
        logic [31:0]        qty;
        logic signed [31:0] tq;
    } order_msg_t;

    typedef struct {
        logic [63:0] oid;
        logic [7:0]  trader;
        logic [1:0]  status;
    } ack_t;

    logic         aclk;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    // trader_id, order_id, instrument_id, side, quantity, trade_quantity, pad
    logic [207:0] s_tdata;
    // op
    logic [2:0]   s_tuser;
    logic         m_tvalid;
    logic         m_tready;
    // resp_order_id, resp_trader_id
    logic [71:0]  m_tdata;
    // status
    logic [1:0]   m_tuser;
    logic         psel;
    logic         penable;
    logic         pwrite;
    logic [2:0]   paddr;
    logic [31:0]  pwdata;
    logic [31:0]  prdata;
    logic         pready;

    pretrade_position_risk_check uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // shadow of the limits and of both tables
    logic [30:0]     buy_cap, sell_cap;
    bit              book_valid [POS_SLOTS];
    longint unsigned book_inst  [POS_SLOTS];
    longint          book_net   [POS_SLOTS];
    longint unsigned book_obuy  [POS_SLOTS];
    longint unsigned book_osell [POS_SLOTS];
    bit              rest_valid [ORD_SLOTS];
    longint unsigned rest_key   [ORD_SLOTS];
    longint unsigned rest_qty   [ORD_SLOTS];
    longint unsigned rest_inst  [ORD_SLOTS];
    bit              rest_side  [ORD_SLOTS];
    logic [7:0]      rest_owner [ORD_SLOTS];

    ack_t        pending_acks[$];
    logic [63:0] key_pool  [KEY_POOL];
    logic [63:0] inst_pool [INST_POOL];
    int          errors;
    int          idle_cycles;
    int          hold_left;
    bit          quiet;

    // ---------------------------------------------------------------
    // Position arithmetic
    // ---------------------------------------------------------------
    function automatic longint unsigned sat_add(longint unsigned a, longint unsigned b);
        longint unsigned s;
        s = a + b;
        if (s < a || s > POS_UMAX)
            return POS_UMAX;
        return s;
    endfunction

    function automatic longint unsigned sub_floor(longint unsigned a, longint unsigned b);
        return (a > b) ? a - b : 0;
    endfunction

    function automatic longint unsigned long_part(longint n);
        return (n > 0) ? longint'(n) : 0;
    endfunction

    function automatic longint unsigned short_part(longint n);
        return (n < 0) ? longint'(-n) : 0;
    endfunction

    function automatic int book_find(longint unsigned key);
        for (int i = 0; i < POS_SLOTS; i++)
            if (book_valid[i] && book_inst[i] == key)
                return i;
        return -1;
    endfunction

    function automatic int book_claim(longint unsigned key);
        for (int i = 0; i < POS_SLOTS; i++)
            if (!book_valid[i]) begin
                book_valid[i] = 1;
                book_inst[i]  = key;
                book_net[i]   = 0;
                book_obuy[i]  = 0;
                book_osell[i] = 0;
                return i;
            end
        return -1;
    endfunction

    function automatic void book_tidy(int p);
        if (book_net[p] == 0 && book_obuy[p] == 0 && book_osell[p] == 0)
            book_valid[p] = 0;
    endfunction

    function automatic int rest_find(longint unsigned key);
        for (int i = 0; i < ORD_SLOTS; i++)
            if (rest_valid[i] && rest_key[i] == key)
                return i;
        return -1;
    endfunction

    function automatic void unwind_order(int k);
        int p;
        p = book_find(rest_inst[k]);
        if (p >= 0) begin
            if (rest_side[k])
                book_obuy[p] = sub_floor(book_obuy[p], rest_qty[k]);
            else
                book_osell[p] = sub_floor(book_osell[p], rest_qty[k]);
            book_tidy(p);
        end
        rest_valid[k] = 0;
    endfunction

    // worst-case check, then duplicate key / free slots
    function automatic logic [1:0] admit_order(order_msg_t m);
        int p, k;
        longint net;
        longint unsigned open, worst;
        bit room;
        p = book_find(m.inst);
        net = (p >= 0) ? book_net[p] : 0;
        open = (p >= 0) ? (m.side ? book_obuy[p] : book_osell[p]) : 0;
        worst = sat_add(sat_add(open, m.qty), m.side ? long_part(net) : short_part(net));
        if (worst > (m.side ? longint'(buy_cap) : longint'(sell_cap)))
            return ST_LIMIT;
        k = -1;
        for (int i = ORD_SLOTS - 1; i >= 0; i--)
            if (!rest_valid[i])
                k = i;
        room = 0;
        for (int i = 0; i < POS_SLOTS; i++)
            if (!book_valid[i])
                room = 1;
        if (rest_find(m.oid) >= 0 || k < 0 || (p < 0 && !room))
            return ST_FULL;
        if (p < 0)
            p = book_claim(m.inst);
        if (m.side)
            book_obuy[p] = sat_add(book_obuy[p], m.qty);
        else
            book_osell[p] = sat_add(book_osell[p], m.qty);
        book_tidy(p);
        rest_valid[k] = 1;
        rest_key[k]   = m.oid;
        rest_qty[k]   = m.qty;
        rest_inst[k]  = m.inst;
        rest_side[k]  = m.side;
        rest_owner[k] = m.trader;
        return ST_ACCEPT;
    endfunction

    function automatic void amend_order(order_msg_t m);
        int k, p;
        k = rest_find(m.oid);
        if (k < 0)
            return;
        p = book_find(rest_inst[k]);
        if (p < 0)
            p = book_claim(rest_inst[k]);
        if (p < 0)
            return;
        if (rest_side[k])
            book_obuy[p] = sat_add(sub_floor(book_obuy[p], rest_qty[k]), m.qty);
        else
            book_osell[p] = sat_add(sub_floor(book_osell[p], rest_qty[k]), m.qty);
        rest_qty[k] = m.qty;
        book_tidy(p);
    endfunction

    function automatic void book_fill(order_msg_t m);
        int p;
        longint tq, n;
        tq = m.tq;
        p = book_find(m.inst);
        if (p < 0) begin
            if (tq == 0)
                return;
            p = book_claim(m.inst);
            if (p < 0)
                return;
        end
        n = book_net[p];
        if (tq > 0 && n > POS_NMAX - tq)
            n = POS_NMAX;
        else if (tq < 0 && n < -POS_NMAX - 1 - tq)
            n = -POS_NMAX - 1;
        else
            n = n + tq;
        book_net[p] = n;
        book_tidy(p);
    endfunction

    // apply one accepted beat to the shadow; queue the acknowledgement
    function automatic void book_update(order_msg_t m);
        ack_t a;
        int k;
        case (m.op)
            OP_NEW: begin
                a.oid = m.oid;
                a.trader = m.trader;
                a.status = admit_order(m);
                pending_acks.push_back(a);
            end
            OP_DEL: begin
                k = rest_find(m.oid);
                if (k >= 0)
                    unwind_order(k);
            end
            OP_MOD: amend_order(m);
            OP_TRADE: book_fill(m);
            OP_DISC: begin
                for (int i = 0; i < ORD_SLOTS; i++)
                    if (rest_valid[i] && rest_owner[i] == m.trader)
                        unwind_order(i);
            end
            default: ;
        endcase
    endfunction

    // ---------------------------------------------------------------
    // Clock, receiver, checker, watchdog
    // ---------------------------------------------------------------
    initial begin
        aclk = 0;
        forever #5 aclk = ~aclk;
    end

    // random back-pressure; a pending hold-off wins
    always @(negedge aclk) begin
        if (hold_left > 0) begin
            m_tready = 1'b0;
            hold_left = hold_left - 1;
        end else if (quiet)
            m_tready = 1'b1;
        else
            m_tready = ($urandom_range(99) >= 37);
    end

    task automatic flag(string what, logic [63:0] want, logic [63:0] got);
        errors++;
        if (errors <= 10)
            $display("ERROR %s: expected %h got %h", what, want, got);
    endtask

    // compare each response beat with the oldest expectation
    always @(posedge aclk) begin
        ack_t a;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_acks.size() == 0)
                flag("unexpected response, order id", 0, m_tdata[63:0]);
            else begin
                a = pending_acks.pop_front();
                if (m_tdata[63:0] !== a.oid)
                    flag("order id", a.oid, m_tdata[63:0]);
                if (m_tdata[71:64] !== a.trader)
                    flag("trader", a.trader, m_tdata[71:64]);
                if (m_tuser !== a.status)
                    flag("status", a.status, m_tuser);
            end
        end
    end

    // end the run if nothing moves for too long
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("pretrade_position_risk_check: mismatch");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // Drivers
    // ---------------------------------------------------------------
    task automatic send_item(order_msg_t m);
        if (!quiet && $urandom_range(99) < 37) begin
            s_tvalid = 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge aclk);
        end
        s_tuser = m.op;
        s_tdata = {7'd0, m.tq, m.qty, m.side, m.inst, m.oid, m.trader};
        s_tvalid = 1'b1;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        book_update(m);
        @(negedge aclk);
        s_tvalid = 1'b0;
    endtask

    // wait for every response, then for the block to go idle
    task automatic settle();
        while (pending_acks.size() != 0)
            @(posedge aclk);
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic write_limit(logic [2:0] addr, logic [30:0] val);
        logic [31:0] back;
        psel = 1; pwrite = 1; penable = 0; paddr = addr;
        pwdata = {$urandom_range(1), val};   // top bit is not stored
        @(negedge aclk);
        penable = 1;
        @(posedge aclk);
        while (!pready)
            @(posedge aclk);
        if (addr == ADDR_BUY)
            buy_cap = val;
        else
            sell_cap = val;
        @(negedge aclk);
        // read it back
        pwrite = 0; penable = 0;
        @(negedge aclk);
        penable = 1;
        @(posedge aclk);
        while (!pready)
            @(posedge aclk);
        back = prdata;
        @(negedge aclk);
        psel = 0; penable = 0;
        if (back[30:0] !== val)
            flag("limit read-back", val, back);
    endtask

    task automatic set_limits(logic [30:0] b, logic [30:0] s);
        settle();
        write_limit(ADDR_BUY, b);
        write_limit(ADDR_SELL, s);
    endtask

    function automatic order_msg_t msg(logic [2:0] op, logic [7:0] trader, logic [63:0] oid,
                                       logic [63:0] inst, logic side, logic [31:0] qty,
                                       logic signed [31:0] tq);
        order_msg_t m;
        m.op = op; m.trader = trader; m.oid = oid; m.inst = inst;
        m.side = side; m.qty = qty; m.tq = tq;
        return m;
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // mostly small, sometimes a full-width quantity
    function automatic logic [31:0] rand_qty();
        case ($urandom_range(9))
            0: return $urandom;
            1: return 0;
            default: return $urandom_range(1, 400);
        endcase
    endfunction

    function automatic order_msg_t rand_msg();
        order_msg_t m;
        int r;
        r = $urandom_range(99);
        m.op = (r < 45) ? OP_NEW : (r < 60) ? OP_DEL : (r < 75) ? OP_MOD :
               (r < 95) ? OP_TRADE : (r < 97) ? OP_DISC : 3'($urandom_range(5, 7));
        m.trader = ($urandom_range(9) == 0) ? 8'($urandom) : 8'($urandom_range(7));
        m.oid = ($urandom_range(19) == 0) ? rand64() : key_pool[$urandom_range(KEY_POOL - 1)];
        m.inst = ($urandom_range(19) == 0) ? rand64() : inst_pool[$urandom_range(INST_POOL - 1)];
        m.side = $urandom_range(1);
        m.qty = rand_qty();
        m.tq = ($urandom_range(9) == 0) ? $urandom : $signed($urandom_range(800)) - 400;
        return m;
    endfunction

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------
    task automatic test_directed();
        logic [63:0] ia, ib;
        ia = inst_pool[0];
        ib = inst_pool[1];
        // zero limits: a zero quantity passes, anything else is held back
        send_item(msg(OP_NEW, 8'd1, 64'd1, ia, 1'b1, 32'd0, 0));
        send_item(msg(OP_NEW, 8'd1, 64'd2, ia, 1'b0, 32'd1, 0));
        set_limits(31'd1000, 31'd1000);
        send_item(msg(OP_NEW, 8'd1, 64'd3, ia, 1'b1, 32'd1000, 0));
        send_item(msg(OP_NEW, 8'd1, 64'd4, ia, 1'b1, 32'd1, 0));
        send_item(msg(OP_NEW, 8'd2, 64'd3, ib, 1'b1, 32'd5, 0));       // duplicate key
        send_item(msg(OP_MOD, 8'd1, 64'd99, ia, 1'b1, 32'd7, 0));      // unknown order
        send_item(msg(OP_MOD, 8'd1, 64'd3, ia, 1'b1, 32'd500, 0));
        send_item(msg(OP_NEW, 8'd1, 64'd5, ia, 1'b1, 32'd500, 0));
        send_item(msg(OP_DEL, 8'd1, 64'd98, ia, 1'b1, 32'd0, 0));      // unknown order
        send_item(msg(OP_DEL, 8'd1, 64'd3, ia, 1'b1, 32'd0, 0));
        send_item(msg(OP_TRADE, 8'd1, 64'd0, ib, 1'b0, 32'd0, 0));     // nothing to create
        send_item(msg(OP_TRADE, 8'd1, 64'd0, ib, 1'b0, 32'd0, 300));
        send_item(msg(OP_NEW, 8'd2, 64'd6, ib, 1'b1, 32'd701, 0));     // long net counts
        send_item(msg(OP_TRADE, 8'd1, 64'd0, ib, 1'b0, 32'd0, -900));
        send_item(msg(OP_NEW, 8'd2, 64'd7, ib, 1'b0, 32'd401, 0));     // short net counts
        send_item(msg(OP_NEW, 8'd2, 64'd8, ib, 1'b0, 32'd400, 0));
        send_item(msg(OP_TRADE, 8'd1, 64'd0, ib, 1'b0, 32'd0, 600));   // net back to zero
        send_item(msg(OP_DISC, 8'd2, 64'd0, ia, 1'b0, 32'd0, 0));
        send_item(msg(OP_DISC, 8'd1, 64'd0, ia, 1'b0, 32'd0, 0));
        send_item(msg(3'd5, 8'd1, 64'd10, ia, 1'b1, 32'd1, 1));
        send_item(msg(3'd6, 8'd1, 64'd10, ia, 1'b1, 32'd1, 1));
        send_item(msg(3'd7, 8'd1, 64'd10, ia, 1'b1, 32'd1, 1));
        // widest fields against the widest limits
        set_limits(LIM_MAX, LIM_MAX);
        send_item(msg(OP_NEW, 8'hFF, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF,
                      1'b1, 32'hFFFF_FFFF, 0));
        send_item(msg(OP_NEW, 8'hFF, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF,
                      1'b1, 32'h7FFF_FFFF, 32'sh7FFF_FFFF));
        send_item(msg(OP_TRADE, 8'hFF, 64'd0, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 32'd0,
                      32'sh8000_0000));
        send_item(msg(OP_DISC, 8'hFF, 64'd0, 64'd0, 1'b0, 32'd0, 0));
    endtask

    // more orders and instruments than the tables hold
    task automatic test_table_full();
        set_limits(LIM_MAX, LIM_MAX);
        for (int i = 0; i < ORD_SLOTS + 8; i++)
            send_item(msg(OP_NEW, 8'(8 + i % 4), key_pool[i], inst_pool[i % INST_POOL],
                          1'($urandom_range(1)), 32'($urandom_range(1, 50)), 0));
        send_item(msg(OP_MOD, 8'd8, key_pool[0], 64'd0, 1'b0, 32'd0, 0));
        for (int t = 8; t < 12; t++)
            send_item(msg(OP_DISC, 8'(t), 64'd0, 64'd0, 1'b0, 32'd0, 0));
    endtask

    // receiver holds off while the sender keeps offering new orders
    task automatic test_backpressure();
        settle();
        hold_left = HOLD_CYCLES;
        for (int i = 0; i < 12; i++)
            send_item(msg(OP_NEW, 8'd3, rand64(), inst_pool[2], 1'b0, 32'd1, 0));
        settle();
    endtask

    task automatic test_random();
        logic [30:0] caps [5];
        caps = '{31'd0, LIM_MAX, 31'd500, 31'd5000, 31'($urandom)};
        for (int ph = 0; ph < 5; ph++) begin
            set_limits(caps[ph], caps[(ph + 2) % 5]);
            quiet = (ph == 3);
            for (int i = 0; i < 210; i++)
                send_item(rand_msg());
        end
        quiet = 0;
    endtask

    initial begin
        aresetn = 0; s_tvalid = 0; s_tdata = '0; s_tuser = OP_NEW; m_tready = 0;
        psel = 0; penable = 0; pwrite = 0; paddr = ADDR_BUY; pwdata = '0;
        errors = 0; idle_cycles = 0; hold_left = 0; quiet = 0;
        buy_cap = '0; sell_cap = '0;
        foreach (book_valid[i]) book_valid[i] = 0;
        foreach (rest_valid[i]) rest_valid[i] = 0;
        foreach (key_pool[i]) key_pool[i] = rand64();
        foreach (inst_pool[i]) inst_pool[i] = rand64();
        inst_pool[INST_POOL - 1] = '0;
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1;

        test_directed();
        test_table_full();
        test_backpressure();
        test_random();

        // let the last beats drain
        settle();
        repeat (50) @(posedge aclk);
        if (pending_acks.size() != 0)
            flag("responses still outstanding", 0, pending_acks.size());
        if (errors == 0)
            $display("pretrade_position_risk_check: match");
        else
            $display("pretrade_position_risk_check: mismatch");
        $finish;
    end

endmodule
